// ===== rtl/insertion_sort_median_filter_unit_defines.svh =====
// assertion macros for the median filter checker
// no dependencies; included by the checker file only
`ifndef INSERTION_SORT_MEDIAN_FILTER_UNIT_DEFINES_SVH
`define INSERTION_SORT_MEDIAN_FILTER_UNIT_DEFINES_SVH

// same-cycle implication, reset masks the check
`define ISMF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ismf check failed");

// next-cycle implication, reset masks the check
`define ISMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ismf check failed");

`endif

// ===== rtl/ismf_pkg.sv =====
// shared types and constants for the insertion sort median filter
// no dependencies
package ismf_pkg;

    localparam int HEADING_W = 16;
    localparam int WLEN_W    = 8;

    localparam logic [WLEN_W-1:0] WINDOW_RESET = 8'd5;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_PUT  = 5'b00100,
        S_FIN  = 5'b01000,
        S_MED  = 5'b10000
    } ismf_state_t;

    typedef struct packed {
        logic idle;
        logic med_valid;
    } ismf_status_t;

endpackage

// ===== rtl/ismf_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ismf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ismf_insert.sv =====
// insertion engine: scans the sorted store top down, shifting entries up
// depends on ismf_pkg and ismf_ram
module ismf_insert #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ismf_pkg::HEADING_W-1:0] sample,
    input  logic [ismf_pkg::WLEN_W-1:0]    eff_len,
    input  logic                          out_free,
    output ismf_pkg::ismf_status_t         status,
    output logic [ismf_pkg::HEADING_W-1:0] med_data
);

    localparam int AW = $clog2(MAX_WINDOW);

    ismf_pkg::ismf_state_t state_reg, state_next;
    logic [ismf_pkg::WLEN_W-1:0]    fill_reg, fill_next;
    logic [AW-1:0]                  idx_reg, idx_next;
    logic [ismf_pkg::HEADING_W-1:0] sample_reg, sample_next;

    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [ismf_pkg::HEADING_W-1:0] wr_data;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [ismf_pkg::HEADING_W-1:0] rd_data;
    logic [ismf_pkg::WLEN_W:0]      cnt_inc;
    logic [ismf_pkg::WLEN_W-1:0]    mid;
    logic                           med_valid;

    ismf_ram #(
        .WIDTH (ismf_pkg::HEADING_W),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cnt_inc = {1'b0, fill_reg} + 9'd1;
    assign mid     = eff_len >> 1;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        sample_next = sample_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg + AW'(1);
        wr_data     = sample_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_reg - AW'(1);
        med_valid   = 1'b0;
        case (state_reg)
            ismf_pkg::S_IDLE:
            begin
                if (start)
                begin
                    sample_next = sample;
                    if (fill_reg == '0)
                    begin
                        // empty store, first entry goes straight in
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = sample;
                        state_next = ismf_pkg::S_FIN;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = fill_reg[AW-1:0] - AW'(1);
                        idx_next   = fill_reg[AW-1:0] - AW'(1);
                        state_next = ismf_pkg::S_SCAN;
                    end
                end
            end
            ismf_pkg::S_SCAN:
            begin
                wr_en = 1'b1;
                if (rd_data >= sample_reg)
                begin
                    // shift entry up one place
                    wr_data = rd_data;
                    if (idx_reg == '0)
                    begin
                        state_next = ismf_pkg::S_PUT;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        idx_next = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    state_next = ismf_pkg::S_FIN;
                end
            end
            ismf_pkg::S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                state_next = ismf_pkg::S_FIN;
            end
            ismf_pkg::S_FIN:
            begin
                if (cnt_inc >= {1'b0, eff_len})
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mid[AW-1:0];
                    state_next = ismf_pkg::S_MED;
                end
                else
                begin
                    fill_next  = cnt_inc[ismf_pkg::WLEN_W-1:0];
                    state_next = ismf_pkg::S_IDLE;
                end
            end
            ismf_pkg::S_MED:
            begin
                if (out_free)
                begin
                    med_valid  = 1'b1;
                    fill_next  = '0;
                    state_next = ismf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ismf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ismf_pkg::S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        sample_reg <= sample_next;
    end

    assign status.idle      = (state_reg == ismf_pkg::S_IDLE);
    assign status.med_valid = med_valid;
    assign med_data         = rd_data;

endmodule

// ===== rtl/insertion_sort_median_filter_unit.sv =====
// median filter by insertion sort: each accepted item is placed in the sorted
// store by a top-down scan, one ram entry per cycle, unless the store is empty;
// a new item is taken only once the engine is idle again, after any output stall
// with the window full the median is read, then enters the output register once free
// reset (rst_n, async, active low) empties the window and sets the length to 5;
// store contents are not cleared, only written entries are ever read
module insertion_sort_median_filter_unit #(
    parameter int MAX_WINDOW = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // [15:0] raw_heading
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // [15:0] median_heading
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data   // [7:0] window_length
);

    localparam int CAP_RAW = (MAX_WINDOW - 1) | 1;
    localparam int CAP_LEN = (CAP_RAW > MAX_WINDOW) ? (MAX_WINDOW - 1) : CAP_RAW;

    logic [ismf_pkg::WLEN_W-1:0]    wlen_reg;
    logic [ismf_pkg::WLEN_W-1:0]    wlen_odd;
    logic [ismf_pkg::WLEN_W-1:0]    eff_len;
    logic                           out_valid_reg, out_valid_next;
    logic [ismf_pkg::HEADING_W-1:0] out_data_reg;
    logic                           out_free;
    ismf_pkg::ismf_status_t         status;
    logic [ismf_pkg::HEADING_W-1:0] med_data;

    // even lengths round up to odd, then clamp to capacity
    assign wlen_odd = wlen_reg | 8'd1;
    assign eff_len  = (wlen_odd > 8'(CAP_LEN)) ? 8'(CAP_LEN) : wlen_odd;
    assign out_free = !out_valid_reg || m_tready;

    ismf_insert #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_insert (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (s_tvalid && s_tready),
        .sample   (s_tdata),
        .eff_len  (eff_len),
        .out_free (out_free),
        .status   (status),
        .med_data (med_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (status.med_valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= ismf_pkg::WINDOW_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                wlen_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.med_valid)
        begin
            out_data_reg <= med_data;
        end
    end

    assign s_tready = status.idle;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/ismf_checker.sv =====
// port-level checks for the median filter, bound to the top level
// depends on insertion_sort_median_filter_unit_defines.svh
`include "insertion_sort_median_filter_unit_defines.svh"

module ismf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result stays offered and unchanged
    `ISMF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `ISMF_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))

    // the engine is busy in the cycle after taking an item
    `ISMF_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)

    // a new result only appears when an item was being worked on
    `ISMF_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), $past(!s_tready))

endmodule

bind insertion_sort_median_filter_unit ismf_checker u_ismf_checker (.*);
